>>> rtl/ppp_pkg.sv
// ppp_pkg: types, register codes, reset values and widths of the perspective point projector
// no dependencies; imported by ppp_cfg_regs, ppp_dot, the top module and the testbench
`default_nettype none

package ppp_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EYE_X      = 4'd0,
    REG_EYE_Y      = 4'd1,
    REG_EYE_Z      = 4'd2,
    REG_FWD_AXIS   = 4'd3,
    REG_RIGHT_AXIS = 4'd4,
    REG_UP_AXIS    = 4'd5,
    REG_VIEW_SCALE = 4'd6,
    REG_VIEWPORT   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic [47:0]        fwd_axis;
    logic [47:0]        right_axis;
    logic [47:0]        up_axis;
    logic [31:0]        view_scale;
    logic [23:0]        viewport;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    eye_x:      32'sd0,
    eye_y:      32'sd0,
    eye_z:      32'sd0,
    fwd_axis:   48'd16384,
    right_axis: 48'd211106232532992,
    up_axis:    48'd1073741824,
    view_scale: 32'd236984606,
    viewport:   24'd5243600
  };

  // dot products, Q.22
  localparam int DOT_W = 51;
  localparam logic signed [DOT_W-1:0] NEAR_Q22 = 51'sd209715;

  // projection dividers
  localparam int Z12_W = 39;
  localparam int NUM_W = 60;
  localparam int NQ_W  = 53;

  // edge direction dividers
  localparam int MAG_W   = 53;
  localparam int DIR_D_W = 40;
  localparam int DIR_N_W = 55;
  localparam int DIR_Q_W = 15;

  typedef struct packed {
    logic signed [DOT_W-1:0] zf;
    logic signed [DOT_W-1:0] xr;
    logic signed [DOT_W-1:0] yu;
    logic [10:0]             margin;
  } dot_t;

  // floor(side * 36 / 5), reciprocal multiply exact below 2^18
  function automatic logic [14:0] inset_limit(input logic [11:0] side);
    logic [17:0] v;
    logic [33:0] p;
    v = 18'(side) * 18'd36;
    p = 34'(v) * 34'd52429;
    return p[32:18];
  endfunction

endpackage

`default_nettype wire

>>> rtl/ppp_if.sv
// ppp_if: point, result and register write channels of the projector
// plain valid/ready interfaces, no package needed
`default_nettype none

interface ppp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic [10:0]        edge_margin;
  modport source (output valid, world_x, world_y, world_z, edge_margin, input ready);
  modport sink (input valid, world_x, world_y, world_z, edge_margin, output ready);
endinterface

interface ppp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] depth;
  logic               behind;
  logic               on_screen;
  logic [15:0]        screen_x;
  logic [15:0]        screen_y;
  logic [23:0]        pixels_per_metre;
  logic signed [15:0] edge_dir_x;
  logic signed [15:0] edge_dir_y;
  logic [15:0]        edge_point_x;
  logic [15:0]        edge_point_y;
  modport source (output valid, depth, behind, on_screen, screen_x, screen_y,
                  pixels_per_metre, edge_dir_x, edge_dir_y, edge_point_x, edge_point_y,
                  input ready);
  modport sink (input valid, depth, behind, on_screen, screen_x, screen_y,
                pixels_per_metre, edge_dir_x, edge_dir_y, edge_point_x, edge_point_y,
                output ready);
endinterface

interface ppp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/ppp_cfg_regs.sv
// ppp_cfg_regs: camera register file written over the register channel
// depends on ppp_pkg and ppp_cfg_if
`default_nettype none

module ppp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  ppp_cfg_if.sink       cfg_ch,
  output ppp_pkg::cfg_t regs
);
  import ppp_pkg::*;

  cfg_t regs_r;

  assign cfg_ch.ready = 1'b1;
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_EYE_X:      regs_r.eye_x <= $signed(cfg_ch.data[31:0]);
        REG_EYE_Y:      regs_r.eye_y <= $signed(cfg_ch.data[31:0]);
        REG_EYE_Z:      regs_r.eye_z <= $signed(cfg_ch.data[31:0]);
        REG_FWD_AXIS:   regs_r.fwd_axis <= cfg_ch.data;
        REG_RIGHT_AXIS: regs_r.right_axis <= cfg_ch.data;
        REG_UP_AXIS:    regs_r.up_axis <= cfg_ch.data;
        REG_VIEW_SCALE: regs_r.view_scale <= cfg_ch.data[31:0];
        REG_VIEWPORT:   regs_r.viewport <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ppp_dot.sv
// ppp_dot: eye offset, nine axis products and three dot products over three stages
// depends on ppp_pkg
`default_nettype none

module ppp_dot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic [10:0]        edge_margin,
  input  ppp_pkg::cfg_t      cfg,
  output logic               out_valid,
  output ppp_pkg::dot_t      out_dot
);
  import ppp_pkg::*;

  logic [2:0]         vld_r;
  logic signed [32:0] d_r [3];
  logic [10:0]        mg1_r, mg2_r;
  logic signed [15:0] ax [3][3];
  logic signed [48:0] prod_nxt [9];
  logic signed [48:0] prod_r [9];
  dot_t               dot_r;

  always_comb begin
    ax[0][0] = cfg.fwd_axis[47:32];
    ax[0][1] = cfg.fwd_axis[31:16];
    ax[0][2] = cfg.fwd_axis[15:0];
    ax[1][0] = cfg.right_axis[47:32];
    ax[1][1] = cfg.right_axis[31:16];
    ax[1][2] = cfg.right_axis[15:0];
    ax[2][0] = cfg.up_axis[47:32];
    ax[2][1] = cfg.up_axis[31:16];
    ax[2][2] = cfg.up_axis[15:0];
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[a*3+c] = 49'(d_r[c]) * 49'(ax[a][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= 33'(world_x) - 33'(cfg.eye_x);
      d_r[1] <= 33'(world_y) - 33'(cfg.eye_y);
      d_r[2] <= 33'(world_z) - 33'(cfg.eye_z);
      mg1_r  <= edge_margin;
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      mg2_r        <= mg1_r;
      dot_r.zf     <= DOT_W'(prod_r[0]) + DOT_W'(prod_r[1]) + DOT_W'(prod_r[2]);
      dot_r.xr     <= DOT_W'(prod_r[3]) + DOT_W'(prod_r[4]) + DOT_W'(prod_r[5]);
      dot_r.yu     <= DOT_W'(prod_r[6]) + DOT_W'(prod_r[7]) + DOT_W'(prod_r[8]);
      dot_r.margin <= mg2_r;
    end
  end

  assign out_valid = vld_r[2];
  assign out_dot   = dot_r;

endmodule

`default_nettype wire

>>> rtl/ppp_div_pipe.sv
// ppp_div_pipe: unsigned restoring divider, one quotient bit per pipeline stage
// no package needed; dividend must be below divisor * 2^Q
`default_nettype none

module ppp_div_pipe #(
  parameter int N = 8,
  parameter int D = 4,
  parameter int Q = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [Q-1:0] quotient
);

  logic [D-1:0]   rem_r [Q];
  logic [Q-1:0]   lo_r  [Q];
  logic [Q-1:0]   quo_r [Q];
  logic [D-1:0]   dvs_r [Q];
  logic [N+D-1:0] ext;

  assign ext = {{D{1'b0}}, dividend};

  for (genvar g = 0; g < Q; g++) begin : g_stage
    logic [D-1:0] rem_in;
    logic [D-1:0] dvs_in;
    logic [Q-1:0] lo_in;
    logic [Q-1:0] quo_in;
    logic [D:0]   trial;
    logic         take;

    if (g == 0) begin : g_first
      assign rem_in = ext[Q+D-1:Q];
      assign lo_in  = dividend[Q-1:0];
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign lo_in  = lo_r[g-1];
      assign quo_in = quo_r[g-1];
      assign dvs_in = dvs_r[g-1];
    end

    assign trial = {rem_in, lo_in[Q-1]};
    assign take  = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? D'(trial - {1'b0, dvs_in}) : trial[D-1:0];
        lo_r[g]  <= {lo_in[Q-2:0], 1'b0};
        quo_r[g] <= {quo_in[Q-2:0], take};
        dvs_r[g] <= dvs_in;
      end
    end
  end

  assign quotient = quo_r[Q-1];

endmodule

`default_nettype wire

>>> rtl/ppp_delay.sv
// ppp_delay: valid and payload delay line that keeps sideband beside a divider
// no package needed
`default_nettype none

module ppp_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = data_r[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/perspective_point_projector_top.sv
// Perspective point projector: projects one world point per transfer onto the viewport.
// Channels: in_ch carries world_x/y/z (Q24.8 m) and edge_margin; out_ch returns depth,
// behind, on_screen, screen position, pixels per metre, edge direction and edge point.
// cfg_ch writes the camera registers (eye, three axes, view scale, viewport) by index and
// is always ready; the user writes it only while the pipeline is empty (not enforced).
// Throughput is one point per cycle unless the receiver stalls. The work is a fixed
// pipeline of dot products, a 53-stage divider for the projection, one quotient bit
// per stage, and a 15-stage divider for the edge direction, each stage a short subtract
// and compare.
// When the receiver stalls, the whole pipeline holds and in_ch.ready falls; the output
// register keeps its result until taken and a new point enters as soon as it is.
// Reset (rst_n, synchronous) empties the pipeline and loads the default camera:
// eye at the origin, forward +z, 1280 x 720 viewport.
// depends on ppp_pkg, ppp_if, ppp_cfg_regs, ppp_dot, ppp_div_pipe, ppp_delay
`default_nettype none

module perspective_point_projector_top (
  input  logic       clk,
  input  logic       rst_n,
  ppp_in_if.sink     in_ch,
  ppp_out_if.source  out_ch,
  ppp_cfg_if.sink    cfg_ch
);
  import ppp_pkg::*;

  typedef struct packed {
    logic signed [31:0]      depth;
    logic                    behind;
    logic                    neg_x;
    logic                    neg_y;
    logic signed [DOT_W-1:0] xr;
    logic signed [DOT_W-1:0] yu;
    logic [14:0]             mx;
    logic [14:0]             my;
  } side_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic               behind;
    logic               on;
    logic [15:0]        scr_x;
    logic [15:0]        scr_y;
    logic [23:0]        ppm;
    logic               sgn_x;
    logic               sgn_y;
    logic [14:0]        mx;
    logic [14:0]        my;
  } edge_t;

  typedef struct packed {
    edge_t info;
    logic  zero;
  } fside_t;

  cfg_t        cfg;
  logic        adv;
  logic        out_valid_r;
  logic [11:0] w_eff, h_eff;
  logic [15:0] sc_x, sc_y;
  logic [14:0] lim_x, lim_y;

  ppp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (cfg)
  );

  assign w_eff = (cfg.viewport[23:12] == 12'd0) ? 12'd1 : cfg.viewport[23:12];
  assign h_eff = (cfg.viewport[11:0] == 12'd0) ? 12'd1 : cfg.viewport[11:0];
  assign sc_x  = cfg.view_scale[31:16];
  assign sc_y  = cfg.view_scale[15:0];
  assign lim_x = inset_limit(w_eff);
  assign lim_y = inset_limit(h_eff);

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // dot products
  logic dot_valid;
  dot_t dot_q;

  ppp_dot u_dot (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (in_ch.valid),
    .world_x     (in_ch.world_x),
    .world_y     (in_ch.world_y),
    .world_z     (in_ch.world_z),
    .edge_margin (in_ch.edge_margin),
    .cfg         (cfg),
    .out_valid   (dot_valid),
    .out_dot     (dot_q)
  );

  // depth, near test and divider operands
  logic signed [DOT_W-1:0] zr;
  logic signed [36:0]      dq;
  logic signed [40:0]      ax_f, ay_f;
  logic [40:0]             ax_m, ay_m;
  logic [14:0]             mg16;
  logic [Z12_W-1:0]        z12_nxt;
  side_t                   side_nxt;
  logic [NUM_W-1:0]        num_x_nxt, num_y_nxt, num_p_nxt;

  always_comb begin
    zr   = dot_q.zf + DOT_W'(8192);
    dq   = zr[DOT_W-1:14];
    ax_f = dot_q.xr[DOT_W-1:10];
    ay_f = dot_q.yu[DOT_W-1:10];
    ax_m = ax_f[40] ? 41'(-ax_f) : 41'(ax_f);
    ay_m = ay_f[40] ? 41'(-ay_f) : 41'(ay_f);
    mg16 = {dot_q.margin, 4'd0};
    z12_nxt = dot_q.zf[Z12_W+9:10];
    if (dq > 37'sd2147483647) begin
      side_nxt.depth = 32'sh7FFFFFFF;
    end else if (dq < -37'sd2147483648) begin
      side_nxt.depth = 32'sh80000000;
    end else begin
      side_nxt.depth = dq[31:0];
    end
    side_nxt.behind = dot_q.zf <= NEAR_Q22;
    side_nxt.neg_x  = ax_f[40];
    side_nxt.neg_y  = ay_f[40];
    side_nxt.xr     = dot_q.xr;
    side_nxt.yu     = dot_q.yu;
    side_nxt.mx     = (mg16 > lim_x) ? lim_x : mg16;
    side_nxt.my     = (mg16 > lim_y) ? lim_y : mg16;
    num_x_nxt = (NUM_W'(ax_m[39:0]) * NUM_W'(sc_x)) << 4;
    num_y_nxt = (NUM_W'(ay_m[39:0]) * NUM_W'(sc_y)) << 4;
    num_p_nxt = ((NUM_W'(h_eff) * NUM_W'(sc_y)) << 7) + NUM_W'(z12_nxt[Z12_W-1:1]);
  end

  logic             s4_valid_r;
  side_t            side_r;
  logic [Z12_W-1:0] z12_r;
  logic [NUM_W-1:0] num_x_r, num_y_r, num_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= dot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r  <= side_nxt;
      z12_r   <= z12_nxt;
      num_x_r <= num_x_nxt;
      num_y_r <= num_y_nxt;
      num_p_r <= num_p_nxt;
    end
  end

  // projection dividers
  logic [NQ_W-1:0] qx, qy, qp;
  logic            sd_valid;
  side_t           sd;

  ppp_div_pipe #(.N(NUM_W), .D(Z12_W), .Q(NQ_W)) u_div_x (
    .clk (clk), .en (adv), .dividend (num_x_r), .divisor (z12_r), .quotient (qx)
  );
  ppp_div_pipe #(.N(NUM_W), .D(Z12_W), .Q(NQ_W)) u_div_y (
    .clk (clk), .en (adv), .dividend (num_y_r), .divisor (z12_r), .quotient (qy)
  );
  ppp_div_pipe #(.N(NUM_W), .D(Z12_W), .Q(NQ_W)) u_div_p (
    .clk (clk), .en (adv), .dividend (num_p_r), .divisor (z12_r), .quotient (qp)
  );
  ppp_delay #(.W($bits(side_t)), .DEPTH(NQ_W)) u_dly_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s4_valid_r),
    .in_data   (side_r),
    .out_valid (sd_valid),
    .out_data  (sd)
  );

  // screen position, scale and edge source
  logic                   on_nxt;
  logic [17:0]            ux, uy;
  logic [29:0]            sx_p, sy_p;
  logic signed [MAG_W-1:0] xe, ye;
  logic [MAG_W-1:0]       mag_x_nxt, mag_y_nxt;
  edge_t                  e_nxt;

  always_comb begin
    on_nxt = !sd.behind && (qx < NQ_W'(65536)) && (qy < NQ_W'(65536));
    ux = sd.neg_x ? 18'd65536 - 18'(qx[16:0]) : 18'd65536 + 18'(qx[16:0]);
    uy = sd.neg_y ? 18'd65536 + 18'(qy[16:0]) : 18'd65536 - 18'(qy[16:0]);
    sx_p = 30'(ux) * 30'(w_eff) + 30'd4096;
    sy_p = 30'(uy) * 30'(h_eff) + 30'd4096;
    xe = MAG_W'(sd.xr);
    ye = MAG_W'(sd.yu);
    mag_x_nxt = sd.behind ? (xe[MAG_W-1] ? -xe : xe) : qx;
    mag_y_nxt = sd.behind ? (ye[MAG_W-1] ? -ye : ye) : qy;
    e_nxt.depth  = sd.depth;
    e_nxt.behind = sd.behind;
    e_nxt.on     = on_nxt;
    e_nxt.scr_x  = on_nxt ? sx_p[28:13] : 16'd0;
    e_nxt.scr_y  = on_nxt ? sy_p[28:13] : 16'd0;
    e_nxt.ppm    = !on_nxt ? 24'd0 : ((|qp[NQ_W-1:24]) ? 24'hFFFFFF : qp[23:0]);
    e_nxt.sgn_x  = sd.behind ? sd.xr[DOT_W-1] : sd.neg_x;
    e_nxt.sgn_y  = sd.behind ? sd.yu[DOT_W-1] : sd.neg_y;
    e_nxt.mx     = sd.mx;
    e_nxt.my     = sd.my;
  end

  logic             e_valid_r;
  edge_t            e_r;
  logic [MAG_W-1:0] e_mag_x_r, e_mag_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r <= sd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r       <= e_nxt;
      e_mag_x_r <= mag_x_nxt;
      e_mag_y_r <= mag_y_nxt;
    end
  end

  // max-norm scaling into the direction divider range
  logic [MAG_W-1:0]   m_v;
  logic [3:0]         sh;
  logic [DIR_D_W-1:0] mxs, mys, ms;
  logic [DIR_N_W-1:0] dn_x_nxt, dn_y_nxt;
  fside_t             f_nxt;

  always_comb begin
    m_v = (e_mag_x_r > e_mag_y_r) ? e_mag_x_r : e_mag_y_r;
    sh  = '0;
    for (int i = DIR_D_W; i < MAG_W; i++) begin
      if (m_v[i]) begin
        sh = 4'(i - DIR_D_W + 1);
      end
    end
    mxs = DIR_D_W'(e_mag_x_r >> sh);
    mys = DIR_D_W'(e_mag_y_r >> sh);
    ms  = DIR_D_W'(m_v >> sh);
    dn_x_nxt = (DIR_N_W'(mxs) << 14) + DIR_N_W'(ms >> 1);
    dn_y_nxt = (DIR_N_W'(mys) << 14) + DIR_N_W'(ms >> 1);
    f_nxt.info = e_r;
    f_nxt.zero = (m_v == '0);
  end

  logic               f_valid_r;
  fside_t             f_r;
  logic [DIR_N_W-1:0] f_num_x_r, f_num_y_r;
  logic [DIR_D_W-1:0] f_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (adv) begin
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r       <= f_nxt;
      f_num_x_r <= dn_x_nxt;
      f_num_y_r <= dn_y_nxt;
      f_den_r   <= ms;
    end
  end

  // edge direction dividers
  logic [DIR_Q_W-1:0] qdx, qdy;
  logic               fs_valid;
  fside_t             fs;

  ppp_div_pipe #(.N(DIR_N_W), .D(DIR_D_W), .Q(DIR_Q_W)) u_div_dx (
    .clk (clk), .en (adv), .dividend (f_num_x_r), .divisor (f_den_r), .quotient (qdx)
  );
  ppp_div_pipe #(.N(DIR_N_W), .D(DIR_D_W), .Q(DIR_Q_W)) u_div_dy (
    .clk (clk), .en (adv), .dividend (f_num_y_r), .divisor (f_den_r), .quotient (qdy)
  );
  ppp_delay #(.W($bits(fside_t)), .DEPTH(DIR_Q_W)) u_dly_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_valid_r),
    .in_data   (f_r),
    .out_valid (fs_valid),
    .out_data  (fs)
  );

  // signed direction and inset offset products
  logic signed [15:0] dir_x_nxt, dir_y_nxt;
  logic signed [15:0] span_x, span_y;
  logic signed [31:0] prod_x_nxt, prod_y_nxt;

  always_comb begin
    dir_x_nxt = fs.zero ? 16'sd0 : (fs.info.sgn_x ? -16'(qdx) : 16'(qdx));
    dir_y_nxt = fs.zero ? 16'sd0 : (fs.info.sgn_y ? -16'(qdy) : 16'(qdy));
    span_x = {1'b0, w_eff, 3'd0} - 16'(fs.info.mx);
    span_y = {1'b0, h_eff, 3'd0} - 16'(fs.info.my);
    prod_x_nxt = 32'(span_x) * 32'(dir_x_nxt);
    prod_y_nxt = 32'(span_y) * 32'(dir_y_nxt);
  end

  logic               g_valid_r;
  edge_t              g_r;
  logic signed [15:0] g_dir_x_r, g_dir_y_r;
  logic signed [31:0] g_prod_x_r, g_prod_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (adv) begin
      g_valid_r <= fs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r        <= fs.info;
      g_dir_x_r  <= dir_x_nxt;
      g_dir_y_r  <= dir_y_nxt;
      g_prod_x_r <= prod_x_nxt;
      g_prod_y_r <= prod_y_nxt;
    end
  end

  // edge point rounding and clamp
  logic signed [31:0] rx, ry;
  logic signed [17:0] off_x, off_y;
  logic signed [18:0] px_v, py_v, lo_x, lo_y, hi_x, hi_y;
  logic [15:0]        px_nxt, py_nxt;

  always_comb begin
    rx    = g_prod_x_r + 32'sd8192;
    ry    = g_prod_y_r + 32'sd8192;
    off_x = rx[31:14];
    off_y = ry[31:14];
    px_v  = $signed({4'd0, w_eff, 3'd0}) + 19'(off_x);
    py_v  = $signed({4'd0, h_eff, 3'd0}) - 19'(off_y);
    lo_x  = $signed({4'd0, g_r.mx});
    lo_y  = $signed({4'd0, g_r.my});
    hi_x  = $signed({3'd0, w_eff, 4'd0}) - lo_x;
    hi_y  = $signed({3'd0, h_eff, 4'd0}) - lo_y;
    if (px_v < lo_x) begin
      px_nxt = lo_x[15:0];
    end else if (px_v > hi_x) begin
      px_nxt = hi_x[15:0];
    end else begin
      px_nxt = px_v[15:0];
    end
    if (py_v < lo_y) begin
      py_nxt = lo_y[15:0];
    end else if (py_v > hi_y) begin
      py_nxt = hi_y[15:0];
    end else begin
      py_nxt = py_v[15:0];
    end
  end

  // output register
  edge_t              o_r;
  logic signed [15:0] o_dir_x_r, o_dir_y_r;
  logic [15:0]        o_px_r, o_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= g_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r       <= g_r;
      o_dir_x_r <= g_dir_x_r;
      o_dir_y_r <= g_dir_y_r;
      o_px_r    <= px_nxt;
      o_py_r    <= py_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.depth            = o_r.depth;
  assign out_ch.behind           = o_r.behind;
  assign out_ch.on_screen        = o_r.on;
  assign out_ch.screen_x         = o_r.scr_x;
  assign out_ch.screen_y         = o_r.scr_y;
  assign out_ch.pixels_per_metre = o_r.ppm;
  assign out_ch.edge_dir_x       = o_dir_x_r;
  assign out_ch.edge_dir_y       = o_dir_y_r;
  assign out_ch.edge_point_x     = o_px_r;
  assign out_ch.edge_point_y     = o_py_r;

`ifndef SYNTHESIS
  a_on_not_behind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.on_screen && out_ch.behind))
    else $error("point marked on screen while behind");

  a_off_screen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.on_screen) |->
      (out_ch.screen_x == 16'd0 && out_ch.screen_y == 16'd0 &&
       out_ch.pixels_per_metre == 24'd0))
    else $error("off-screen result carries screen data");

  a_dir_max_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.edge_dir_x != 16'sd0 || out_ch.edge_dir_y != 16'sd0)) |->
      (out_ch.edge_dir_x == 16'sd16384 || out_ch.edge_dir_x == -16'sd16384 ||
       out_ch.edge_dir_y == 16'sd16384 || out_ch.edge_dir_y == -16'sd16384))
    else $error("edge direction not unit in max norm");
`endif

endmodule

`default_nettype wire

>>> sim/perspective_point_projector_top_tb.sv
// perspective_point_projector_top_tb: checks the point projector against its own
// exact-integer projection predictor, with random sender and receiver stalls
// depends on ppp_pkg, ppp_if and perspective_point_projector_top
`default_nettype none

module perspective_point_projector_top_tb;
  import ppp_pkg::*;

  typedef struct packed {
    logic signed [31:0] depth;
    logic               behind;
    logic               on_screen;
    logic [15:0]        screen_x;
    logic [15:0]        screen_y;
    logic [23:0]        ppm;
    logic [15:0]        dir_x;
    logic [15:0]        dir_y;
    logic [15:0]        pt_x;
    logic [15:0]        pt_y;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppp_in_if  in_ch();
  ppp_out_if out_ch();
  ppp_cfg_if cfg_ch();

  perspective_point_projector_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  logic [47:0] cam_regs [0:7];
  proj_t       expected_q [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  function automatic longint fshr(longint v, int n);
    if (v < 0) return -1 - ((-1 - v) >>> n);
    return v >>> n;
  endfunction

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint dot3(longint dx, longint dy, longint dz, logic [47:0] a);
    return dx * sx16(a[47:32]) + dy * sx16(a[31:16]) + dz * sx16(a[15:0]);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic proj_t project_point(logic [31:0] wx, logic [31:0] wy,
                                          logic [31:0] wz, logic [10:0] margin);
    proj_t r;
    longint dx, dy, dz, zf, xr, yu, w, h, sxs, sys, z12, nx, ny, ex, ey;
    longint mx, my, dirx, diry, px, py, ppm, sxo, syo;
    logic [63:0] ax, ay, m;
    dx = longint'($signed(wx)) - longint'($signed(cam_regs[REG_EYE_X][31:0]));
    dy = longint'($signed(wy)) - longint'($signed(cam_regs[REG_EYE_Y][31:0]));
    dz = longint'($signed(wz)) - longint'($signed(cam_regs[REG_EYE_Z][31:0]));
    zf = dot3(dx, dy, dz, cam_regs[REG_FWD_AXIS]);
    xr = dot3(dx, dy, dz, cam_regs[REG_RIGHT_AXIS]);
    yu = dot3(dx, dy, dz, cam_regs[REG_UP_AXIS]);
    w = cam_regs[REG_VIEWPORT][23:12];
    h = cam_regs[REG_VIEWPORT][11:0];
    sxs = cam_regs[REG_VIEW_SCALE][31:16];
    sys = cam_regs[REG_VIEW_SCALE][15:0];
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    r = '0;
    r.depth = 32'(clip(fshr(zf + 8192, 14), -64'sd2147483648, 64'sd2147483647));
    r.behind = (zf <= 209715);
    sxo = 0; syo = 0; ppm = 0;
    ex = xr; ey = yu;
    if (!r.behind) begin
      z12 = fshr(zf, 10);
      nx = fshr(xr, 10) * sxs * 16 / z12;
      ny = fshr(yu, 10) * sys * 16 / z12;
      ex = nx; ey = ny;
      if (nx > -65536 && nx < 65536 && ny > -65536 && ny < 65536) begin
        r.on_screen = 1'b1;
        sxo = ((nx + 65536) * w + 4096) >>> 13;
        syo = ((65536 - ny) * h + 4096) >>> 13;
        ppm = (h * sys * 128 + z12 / 2) / z12;
        if (ppm > 24'hFFFFFF) ppm = 24'hFFFFFF;
      end
    end
    dirx = 0; diry = 0; px = w * 8; py = h * 8;
    ax = ex < 0 ? 64'(-ex) : 64'(ex);
    ay = ey < 0 ? 64'(-ey) : 64'(ey);
    m = ax > ay ? ax : ay;
    if (m != 0) begin
      while (m >= (64'd1 << 40)) begin
        ax = ax >> 1; ay = ay >> 1; m = m >> 1;
      end
      dirx = longint'((ax * 16384 + m / 2) / m);
      diry = longint'((ay * 16384 + m / 2) / m);
      if (ex < 0) dirx = -dirx;
      if (ey < 0) diry = -diry;
      mx = longint'(margin) * 16; my = mx;
      if (mx > w * 36 / 5) mx = w * 36 / 5;
      if (my > h * 36 / 5) my = h * 36 / 5;
      px = clip(w * 8 + fshr((w * 8 - mx) * dirx + 8192, 14), mx, w * 16 - mx);
      py = clip(h * 8 - fshr((h * 8 - my) * diry + 8192, 14), my, h * 16 - my);
    end
    r.screen_x = 16'(sxo); r.screen_y = 16'(syo); r.ppm = 24'(ppm);
    r.dir_x = 16'(dirx); r.dir_y = 16'(diry);
    r.pt_x = 16'(px); r.pt_y = 16'(py);
    return r;
  endfunction

  task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                            logic [10:0] margin);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.world_x     <= wx;
    in_ch.world_y     <= wy;
    in_ch.world_z     <= wz;
    in_ch.edge_margin <= margin;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(project_point(wx, wy, wz, margin));
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [47:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_EYE_X, REG_EYE_Y, REG_EYE_Z, REG_VIEW_SCALE: cam_regs[idx] = {16'd0, value[31:0]};
      REG_VIEWPORT: cam_regs[idx] = {24'd0, value[23:0]};
      default: cam_regs[idx] = value;
    endcase
  endtask

  // a point that usually lands in front of the camera
  task automatic send_random_point();
    logic [31:0] wx, wy, wz;
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      wz = $urandom_range(20000, 100);
      wx = 32'($signed($urandom_range(8000)) - 4000);
      wy = 32'($signed($urandom_range(8000)) - 4000);
    end else if (kind < 8) begin
      wz = 32'($signed($urandom_range(4000)) - 3000);
      wx = 32'($signed($urandom_range(200000)) - 100000);
      wy = 32'($signed($urandom_range(200000)) - 100000);
    end else begin
      wx = $urandom; wy = $urandom; wz = $urandom;
    end
    send_point(wx, wy, wz, 11'($urandom));
  endtask

  task automatic test_directed();
    send_point(32'd0, 32'd0, 32'd0, 11'd0);
    send_point(32'd0, 32'd0, 32'd12, 11'd0);
    send_point(32'd0, 32'd0, 32'd13, 11'd5);
    send_point(32'd0, 32'd0, 32'd256, 11'd2047);
    send_point(32'd100, -32'sd50, 32'd256, 11'd10);
    send_point(32'd2000, 32'd0, 32'd256, 11'd20);
    send_point(32'd0, -32'sd3000, 32'd256, 11'd0);
    send_point(32'd500, 32'd500, -32'sd256, 11'd30);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 11'd2047);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 11'd0);
    send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff, 11'd1);
    send_point(32'h7fffffff, 32'h80000000, 32'h80000000, 11'd1024);
    send_point(32'd0, 32'd0, 32'h7fffffff, 11'd100);
    send_point(32'd1, 32'd1, 32'd14, 11'd3);
  endtask

  task automatic test_random_views(int count);
    repeat (count) send_random_point();
  endtask

  task automatic test_camera_settings();
    drain_pipe();
    write_reg(REG_EYE_X, 48'h0000_ffff_ff00);
    write_reg(REG_EYE_Y, 48'h0000_0000_0100);
    write_reg(REG_EYE_Z, 48'h0000_ffff_fe00);
    write_reg(REG_FWD_AXIS, {16'd1000, 16'd0, 16'd16000});
    write_reg(REG_RIGHT_AXIS, {16'hc000, 16'd200, 16'd0});
    write_reg(REG_UP_AXIS, {16'd0, 16'd16384, 16'hff00});
    write_reg(REG_VIEW_SCALE, {16'hffff, 16'd0});
    write_reg(REG_VIEWPORT, 24'h000_000);
    test_random_views(40);
    drain_pipe();
    write_reg(REG_EYE_X, 48'h0000_8000_0000);
    write_reg(REG_EYE_Y, 48'h0000_7fff_ffff);
    write_reg(REG_EYE_Z, 48'h0000_8000_0000);
    write_reg(REG_FWD_AXIS, 48'h8000_8000_8000);
    write_reg(REG_RIGHT_AXIS, 48'h7fff_7fff_7fff);
    write_reg(REG_UP_AXIS, 48'hffff_ffff_ffff);
    write_reg(REG_VIEW_SCALE, 48'hffff_ffff);
    write_reg(REG_VIEWPORT, 24'hfff_fff);
    test_random_views(30);
    drain_pipe();
    write_reg(REG_EYE_X, 48'd0);
    write_reg(REG_EYE_Y, 48'd0);
    write_reg(REG_EYE_Z, 48'd0);
    write_reg(REG_FWD_AXIS, 48'd16384);
    write_reg(REG_RIGHT_AXIS, 48'hc000_0000_0000);
    write_reg(REG_UP_AXIS, 48'h0000_4000_0000);
    write_reg(REG_VIEW_SCALE, {16'd4096, 16'd8192});
    write_reg(REG_VIEWPORT, {12'd64, 12'd1});
    test_random_views(40);
    drain_pipe();
    write_reg(REG_VIEWPORT, 24'h50_02d0);
    write_reg(REG_VIEW_SCALE, 48'h0e20_191e);
    test_directed();
  endtask

  always @(posedge clk) begin
    proj_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.depth, out_ch.behind, out_ch.on_screen, out_ch.screen_x,
                out_ch.screen_y, out_ch.pixels_per_metre, out_ch.edge_dir_x,
                out_ch.edge_dir_y, out_ch.edge_point_x, out_ch.edge_point_y};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.world_x <= '0;
    in_ch.world_y <= '0;
    in_ch.world_z <= '0;
    in_ch.edge_margin <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_EYE_X;
    cfg_ch.data <= '0;
    for (int i = 0; i < 8; i++) cam_regs[i] = 48'(CFG_RESET >> (48 * 3 + 32 + 24 - 0) * 0);
    cam_regs[REG_EYE_X] = '0; cam_regs[REG_EYE_Y] = '0; cam_regs[REG_EYE_Z] = '0;
    cam_regs[REG_FWD_AXIS] = CFG_RESET.fwd_axis;
    cam_regs[REG_RIGHT_AXIS] = CFG_RESET.right_axis;
    cam_regs[REG_UP_AXIS] = CFG_RESET.up_axis;
    cam_regs[REG_VIEW_SCALE] = {16'd0, CFG_RESET.view_scale};
    cam_regs[REG_VIEWPORT] = {24'd0, CFG_RESET.viewport};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 12; recv_idle_pct = 52;
    test_directed();
    test_random_views(120);
    send_idle_pct = 52; recv_idle_pct = 12;
    test_camera_settings();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_views(120);
    drain_pipe();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/ppp_pkg.sv
rtl/ppp_if.sv
rtl/ppp_cfg_regs.sv
rtl/ppp_dot.sv
rtl/ppp_div_pipe.sv
rtl/ppp_delay.sv
rtl/perspective_point_projector_top.sv
sim/perspective_point_projector_top_tb.sv
